>>> rtl/skt_pkg.sv
package skt_pkg;

  // Default sizing
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 16;
  localparam int COUNT_W  = 7;

  // Operation codes carried by in_kind
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SHRD,
    S_SHWR,
    S_RESP
  } state_t;

endpackage

>>> rtl/skt_ram.sv
module skt_ram #(
  parameter int DEPTH     = skt_pkg::CAPACITY_DEF,
  parameter int WIDTH     = skt_pkg::KEY_BITS_DEF + 2 * skt_pkg::DATA_W,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/sorted_key_table.sv
// sorted_key_table: a table of up to CAPACITY entries (key, relevance, handle)
// kept in ascending key order in a single-port-write table memory.
// Input channel (in_*): one operation per transfer: insert, search, remove
// or clear. in_stall is high while an operation is in progress; the block
// works on one operation at a time.
// Result channel (out_*): exactly one result per operation, with status,
// the relevance and handle of the entry found or removed, and the entry
// count after the operation. The result sits in an output register; while
// the receiver holds out_stall the result stays put, and an operation that
// finishes meanwhile waits for the register to empty.
// Sequencing: the table is walked one entry at a time (read, then compare
// and write back) through the one memory read port. Clear, a refused
// insert, and search/remove on an empty table go straight to the result.
// Insert scans and ripple-shifts the entries up to the end; search stops
// at a match, a greater key or the end; remove scans, then closes the gap.
// Reset empties the table (count zero) and drops any pending result;
// table contents are not cleared, only entries below the count are used.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skt_pkg::KIND_W-1:0]    in_kind,
  input  logic [skt_pkg::DATA_W-1:0]    in_entry_key,
  input  logic [skt_pkg::DATA_W-1:0]    in_entry_relevance,
  input  logic [skt_pkg::DATA_W-1:0]    in_entry_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skt_pkg::STATUS_W-1:0]  out_status,
  output logic [skt_pkg::DATA_W-1:0]    out_found_relevance,
  output logic [skt_pkg::DATA_W-1:0]    out_found_handle,
  output logic [skt_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = skt_pkg::DATA_W;
  localparam int EW = KEY_BITS + 2 * DW;
  localparam int NW = skt_pkg::COUNT_W;

  // Control state
  skt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             ins_r, ins_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Operation and result payload
  skt_pkg::kind_t   kind_r, kind_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [DW-1:0]    rel_r, rel_nxt;
  logic [DW-1:0]    hnd_r, hnd_nxt;
  logic [EW-1:0]    carry_r, carry_nxt;
  skt_pkg::status_t res_status_r, res_status_nxt;
  logic [DW-1:0]    res_rel_r, res_rel_nxt;
  logic [DW-1:0]    res_hnd_r, res_hnd_nxt;
  skt_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]    out_rel_r, out_rel_nxt;
  logic [DW-1:0]    out_hnd_r, out_hnd_nxt;
  logic [NW-1:0]    out_cnt_r, out_cnt_nxt;

  // Memory port
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    rd_data;

  // Helpers
  logic [KEY_BITS+DW-1:0] key_ext;
  logic [KEY_BITS-1:0]    in_key;
  logic [KEY_BITS-1:0]    rd_key;
  logic [EW-1:0]          new_entry;
  logic [CW-1:0]          idx_p1;
  logic [CW:0]            idx_p2;
  logic [CW+NW-1:0]       cnt_ext;
  logic                   out_free;

  assign key_ext   = {{KEY_BITS{1'b0}}, in_entry_key};
  assign in_key    = key_ext[KEY_BITS-1:0];
  assign rd_key    = rd_data[EW-1 -: KEY_BITS];
  assign new_entry = {key_r, rel_r, hnd_r};
  assign idx_p1    = idx_r + CW'(1);
  assign idx_p2    = {1'b0, idx_r} + (CW+1)'(2);
  assign cnt_ext   = {{NW{1'b0}}, fill_r};
  assign out_free  = !out_valid_r || !out_stall;

  skt_ram #(
    .DEPTH     (CAPACITY),
    .WIDTH     (EW),
    .ADDR_BITS (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read address: shift phase reads one slot ahead of the write slot
  always_comb begin
    if (state_r == skt_pkg::S_SHRD) begin
      rd_addr = idx_p1[AW-1:0];
    end else begin
      rd_addr = idx_r[AW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    ins_nxt        = ins_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    rel_nxt        = rel_r;
    hnd_nxt        = hnd_r;
    carry_nxt      = carry_r;
    res_status_nxt = res_status_r;
    res_rel_nxt    = res_rel_r;
    res_hnd_nxt    = res_hnd_r;
    out_status_nxt = out_status_r;
    out_rel_nxt    = out_rel_r;
    out_hnd_nxt    = out_hnd_r;
    out_cnt_nxt    = out_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr_en          = 1'b0;
    wr_addr        = idx_r[AW-1:0];
    wr_data        = rd_data;

    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = skt_pkg::kind_t'(in_kind);
          key_nxt        = in_key;
          rel_nxt        = in_entry_relevance;
          hnd_nxt        = in_entry_handle;
          idx_nxt        = '0;
          ins_nxt        = 1'b0;
          res_status_nxt = skt_pkg::STATUS_DONE;
          res_rel_nxt    = '0;
          res_hnd_nxt    = '0;
          case (skt_pkg::kind_t'(in_kind))
            skt_pkg::KIND_INSERT: begin
              if (fill_r == CW'(CAPACITY)) begin
                res_status_nxt = skt_pkg::STATUS_FULL;
                state_nxt      = skt_pkg::S_RESP;
              end else begin
                state_nxt = skt_pkg::S_READ;
              end
            end
            skt_pkg::KIND_SEARCH, skt_pkg::KIND_REMOVE: begin
              if (fill_r == '0) begin
                res_status_nxt = skt_pkg::STATUS_MISS;
                state_nxt      = skt_pkg::S_RESP;
              end else begin
                state_nxt = skt_pkg::S_READ;
              end
            end
            default: begin
              fill_nxt  = '0;
              state_nxt = skt_pkg::S_RESP;
            end
          endcase
        end
      end

      skt_pkg::S_READ: begin
        state_nxt = skt_pkg::S_EVAL;
      end

      skt_pkg::S_EVAL: begin
        if (kind_r == skt_pkg::KIND_INSERT) begin
          // Ripple insert: drop the new entry in place, push the rest up
          if (idx_r == fill_r) begin
            wr_en     = 1'b1;
            wr_data   = ins_r ? carry_r : new_entry;
            fill_nxt  = fill_r + CW'(1);
            state_nxt = skt_pkg::S_RESP;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = skt_pkg::S_READ;
            if (ins_r) begin
              wr_en     = 1'b1;
              wr_data   = carry_r;
              carry_nxt = rd_data;
            end else if (rd_key >= key_r) begin
              wr_en     = 1'b1;
              wr_data   = new_entry;
              carry_nxt = rd_data;
              ins_nxt   = 1'b1;
            end
          end
        end else begin
          // Search or remove: first match, stop at a greater key
          if (rd_key == key_r) begin
            res_rel_nxt = rd_data[2*DW-1 -: DW];
            res_hnd_nxt = rd_data[DW-1:0];
            if (kind_r == skt_pkg::KIND_SEARCH) begin
              state_nxt = skt_pkg::S_RESP;
            end else if (idx_p1 < fill_r) begin
              state_nxt = skt_pkg::S_SHRD;
            end else begin
              fill_nxt  = fill_r - CW'(1);
              state_nxt = skt_pkg::S_RESP;
            end
          end else if (rd_key > key_r || idx_p1 == fill_r) begin
            res_status_nxt = skt_pkg::STATUS_MISS;
            state_nxt      = skt_pkg::S_RESP;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = skt_pkg::S_READ;
          end
        end
      end

      skt_pkg::S_SHRD: begin
        state_nxt = skt_pkg::S_SHWR;
      end

      skt_pkg::S_SHWR: begin
        // Close the gap: slot idx takes slot idx+1
        wr_en   = 1'b1;
        idx_nxt = idx_p1;
        if (idx_p2 < {1'b0, fill_r}) begin
          state_nxt = skt_pkg::S_SHRD;
        end else begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = skt_pkg::S_RESP;
        end
      end

      skt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rel_nxt    = res_rel_r;
          out_hnd_nxt    = res_hnd_r;
          out_cnt_nxt    = cnt_ext[NW-1:0];
          state_nxt      = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = skt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    ins_r        <= ins_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    rel_r        <= rel_nxt;
    hnd_r        <= hnd_nxt;
    carry_r      <= carry_nxt;
    res_status_r <= res_status_nxt;
    res_rel_r    <= res_rel_nxt;
    res_hnd_r    <= res_hnd_nxt;
    out_status_r <= out_status_nxt;
    out_rel_r    <= out_rel_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_stall            = (state_r != skt_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found_relevance = out_rel_r;
  assign out_found_handle    = out_hnd_r;
  assign out_entry_count     = out_cnt_r;

  // Count never exceeds the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // Table writes stay within the occupied region plus one
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} <= (AW+1)'(fill_r)))
    else $error("table write beyond entry count");

  // Count changes only on an accepted clear or at the end of an insert/remove
  a_fill_change: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |->
      ($past(state_r) == skt_pkg::S_IDLE || $past(state_r) == skt_pkg::S_EVAL ||
       $past(state_r) == skt_pkg::S_SHWR))
    else $error("entry count changed mid-operation");

  // A finished operation never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_RESP && out_valid_r && out_stall) |=>
      (state_r == skt_pkg::S_RESP))
    else $error("result dropped while receiver stalled");

  // Scan index never passes the entry count during evaluation
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_EVAL) |-> (idx_r <= fill_r))
    else $error("scan index past entry count");

endmodule
